// ----- hw/rtl/line_follow_pid_steering_defines.svh -----
// Assertion macros shared by the line follow steering controller.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lfps_pkg.sv -----
// Shared types, constants and the microprogram of the line follow steering controller.
// Used by every module and interface of the block; depends on nothing.
package lfps_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 24;

    localparam int COL_W      = 10;
    localparam int SPD_W      = 9;
    localparam int ANG_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 32;
    localparam int Q_W        = 11;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 4'd0,
        REG_KI    = 4'd1,
        REG_KD    = 4'd2,
        REG_SPEED = 4'd3,
        REG_SETPT = 4'd4,
        REG_FRAME = 4'd5,
        REG_BASE  = 4'd6,
        REG_SLOW  = 4'd7
    } cfg_idx_t;

    localparam logic [31:0] KP_RESET    = 32'd125829120;
    localparam logic [31:0] KI_RESET    = 32'd84;
    localparam logic [31:0] KD_RESET    = 32'd4194304;
    localparam logic [31:0] SPEED_RESET = 32'd15729;
    localparam logic [8:0]  SETPT_RESET = 9'd107;
    localparam logic [9:0]  FRAME_RESET = 10'd160;
    localparam logic [7:0]  BASE_RESET  = 8'd80;
    localparam logic [5:0]  SLOW_RESET  = 6'd10;

    // Steering and motor limits.
    localparam logic [ANG_W-1:0]        LOW_LIMIT    = 9'd60;
    localparam logic [ANG_W-1:0]        HIGH_LIMIT   = 9'd154;
    localparam logic [ANG_W-1:0]        STEER_MAX    = 9'd511;
    localparam logic signed [11:0]      STEER_MARGIN = 12'sd50;
    localparam logic signed [11:0]      SPEED_LIMIT  = 12'sd255;
    localparam logic signed [SPD_W-1:0] REV_SPEED    = -9'sd100;
    localparam logic [Q_W-1:0]          Q_CAP        = 11'd1024;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] speed;
        logic [8:0]        set_point;
        logic [9:0]        frame_center;
        logic [7:0]        base_speed;
        logic [5:0]        slow_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP_E,
        MUL_KD_D,
        MUL_KI_SUM,
        MUL_LO_GM,
        MUL_HI_GM
    } mul_sel_t;

    typedef enum logic [1:0] {
        U_HOLD,
        U_LOAD,
        U_ADD,
        U_ADDSAT
    } u_op_t;

    typedef enum logic [1:0] {
        M_HOLD,
        M_LOAD,
        M_ADD_HI
    } m_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_REVERSE,
        EMIT_STOP,
        EMIT_FINAL
    } emit_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_LIMIT
    } jump_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT    = 4'd0;
    localparam step_t ST_MUL_KP  = 4'd1;
    localparam step_t ST_MUL_KD  = 4'd2;
    localparam step_t ST_MUL_KI  = 4'd3;
    localparam step_t ST_SAT     = 4'd4;
    localparam step_t ST_MAG     = 4'd5;
    localparam step_t ST_STEER   = 4'd6;
    localparam step_t ST_MUL_HI  = 4'd7;
    localparam step_t ST_MOT_ADD = 4'd8;
    localparam step_t ST_MOTOR   = 4'd9;
    localparam step_t ST_REVERSE = 4'd10;
    localparam step_t ST_STOP    = 4'd11;
    localparam step_t ST_FINAL   = 4'd12;

    typedef struct packed {
        logic     take_in;
        mul_sel_t mul_sel;
        u_op_t    u_op;
        logic     latch_mag;
        logic     latch_steer;
        m_op_t    m_op;
        logic     latch_motor;
        emit_t    emit;
        jump_t    jump;
        step_t    target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic at_limit;
    } status_t;

    localparam ctrl_t CTRL_IDLE = '{
        take_in:     1'b0,
        mul_sel:     MUL_NONE,
        u_op:        U_HOLD,
        latch_mag:   1'b0,
        latch_steer: 1'b0,
        m_op:        M_HOLD,
        latch_motor: 1'b0,
        emit:        EMIT_NONE,
        jump:        J_NEXT,
        target:      ST_WAIT
    };

    // The microprogram: one control word per step.
    function automatic ctrl_t ucode_word(input step_t s);
        ctrl_t w;
        w = CTRL_IDLE;
        case (s)
            ST_WAIT:    w.take_in = 1'b1;
            ST_MUL_KP:  w.mul_sel = MUL_KP_E;
            ST_MUL_KD:
            begin
                w.mul_sel = MUL_KD_D;
                w.u_op    = U_LOAD;
            end
            ST_MUL_KI:
            begin
                w.mul_sel = MUL_KI_SUM;
                w.u_op    = U_ADD;
            end
            ST_SAT:     w.u_op = U_ADDSAT;
            ST_MAG:     w.latch_mag = 1'b1;
            ST_STEER:
            begin
                w.latch_steer = 1'b1;
                w.mul_sel     = MUL_LO_GM;
            end
            ST_MUL_HI:
            begin
                w.mul_sel = MUL_HI_GM;
                w.m_op    = M_LOAD;
            end
            ST_MOT_ADD: w.m_op = M_ADD_HI;
            ST_MOTOR:
            begin
                w.latch_motor = 1'b1;
                w.jump        = J_NO_LIMIT;
                w.target      = ST_FINAL;
            end
            ST_REVERSE: w.emit = EMIT_REVERSE;
            ST_STOP:    w.emit = EMIT_STOP;
            ST_FINAL:
            begin
                w.emit   = EMIT_FINAL;
                w.jump   = J_ALWAYS;
                w.target = ST_WAIT;
            end
            default:
            begin
                w.jump   = J_ALWAYS;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/lfps_line_if.sv -----
// Input channel of the steering controller: one line centroid column per request.
// Depends on lfps_pkg for the field width.
interface lfps_line_if import lfps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] line_column;

    modport source (output valid, output line_column, input ready);
    modport sink   (input valid, input line_column, output ready);
endinterface

// ----- hw/rtl/lfps_cmd_if.sv -----
// Output channel of the steering controller: one motor and servo command per request.
// Depends on lfps_pkg for the field widths.
interface lfps_cmd_if import lfps_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] left_speed;
    logic signed [SPD_W-1:0] right_speed;
    logic [ANG_W-1:0]        steer_angle;
    logic                    last;

    modport source (output valid, output left_speed, output right_speed,
                    output steer_angle, output last, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input steer_angle, input last, output ready);
endinterface

// ----- hw/rtl/lfps_cfg_if.sv -----
// Configuration write channel of the steering controller.
// Depends on lfps_pkg for the index and data widths.
interface lfps_cfg_if import lfps_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lfps_cfg_regs.sv -----
// Configuration register file of the steering controller.
// Depends on lfps_pkg for the register indexes, reset values and cfg_t.
module lfps_cfg_regs import lfps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_KP:    cfg_next.kp             = wr_data;
                REG_KI:    cfg_next.ki             = wr_data;
                REG_KD:    cfg_next.kd             = wr_data;
                REG_SPEED: cfg_next.speed          = wr_data;
                REG_SETPT: cfg_next.set_point      = wr_data[8:0];
                REG_FRAME: cfg_next.frame_center   = wr_data[9:0];
                REG_BASE:  cfg_next.base_speed     = wr_data[7:0];
                REG_SLOW:  cfg_next.slow_threshold = wr_data[5:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp             <= KP_RESET;
            cfg_reg.ki             <= KI_RESET;
            cfg_reg.kd             <= KD_RESET;
            cfg_reg.speed          <= SPEED_RESET;
            cfg_reg.set_point      <= SETPT_RESET;
            cfg_reg.frame_center   <= FRAME_RESET;
            cfg_reg.base_speed     <= BASE_RESET;
            cfg_reg.slow_threshold <= SLOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/lfps_seq.sv -----
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on lfps_pkg for ctrl_t, status_t and the microprogram.
module lfps_seq import lfps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  stall;
    logic  jump_taken;

    assign ctrl = ucode_word(step_reg);

    // A step that waits on a handshake holds until the handshake can complete.
    assign stall = (ctrl.take_in && !status.in_valid) ||
                   ((ctrl.emit != EMIT_NONE) && !status.out_free);

    assign jump_taken = (ctrl.jump == J_ALWAYS) ||
                        ((ctrl.jump == J_NO_LIMIT) && !status.at_limit);

    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (jump_taken)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- hw/rtl/lfps_datapath.sv -----
// Datapath of the steering controller: error update, shared multiplier, accumulators,
// steering and motor clamps, and the output register. Depends on lfps_pkg.
module lfps_datapath import lfps_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  cfg_t                    cfg,
    input  logic                    in_accept,
    input  logic [COL_W-1:0]        line_column,
    input  logic                    out_ready,
    output status_t                 status_dp,
    output logic                    out_valid,
    output logic signed [SPD_W-1:0] left_speed,
    output logic signed [SPD_W-1:0] right_speed,
    output logic [ANG_W-1:0]        steer_angle,
    output logic                    last
);

    localparam int MOT_W = 97;
    localparam int MSH   = 2 * GAIN_FRAC_BITS + 2;
    localparam logic [63:0]      U_FRAC_MASK = (64'd1 << GAIN_FRAC_BITS) - 64'd1;
    localparam logic [MOT_W-1:0] M_FRAC_MASK = (MOT_W'(1) << MSH) - MOT_W'(1);
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

    // Rounds n + (neg ? -1 : 1) * (q + fraction) toward zero.
    function automatic logic signed [11:0] trunc_sum(input logic [8:0] n, input logic neg,
                                                     input logic [Q_W-1:0] q,
                                                     input logic nz);
        logic signed [11:0] n_s;
        logic signed [11:0] q_s;
        logic signed [11:0] fl;
        n_s = $signed({3'b000, n});
        q_s = $signed({1'b0, q});
        fl  = neg ? (n_s - q_s - {11'd0, nz}) : (n_s + q_s);
        return (fl[11] && nz) ? fl + 12'sd1 : fl;
    endfunction

    function automatic logic signed [SPD_W-1:0] clamp_speed(input logic signed [11:0] v);
        logic signed [11:0] c;
        c = v;
        if (v < -SPEED_LIMIT)
        begin
            c = -SPEED_LIMIT;
        end
        else if (v > SPEED_LIMIT)
        begin
            c = SPEED_LIMIT;
        end
        return c[SPD_W-1:0];
    endfunction

    // Error stage.
    logic signed [7:0]  e_reg, d_reg, prev_reg;
    logic signed [31:0] sum_reg;
    logic signed [11:0] diff;
    logic signed [11:0] diff_adj;
    logic signed [7:0]  e_new;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_new;

    assign diff     = $signed({2'b00, line_column}) - $signed({2'b00, cfg.frame_center});
    assign diff_adj = diff[11] ? diff + 12'sd15 : diff;
    assign e_new    = diff_adj[11:4];
    assign sum_wide = $signed({sum_reg[31], sum_reg}) + $signed({{25{e_new[7]}}, e_new});

    always_comb
    begin
        if (sum_wide[32] != sum_wide[31])
        begin
            sum_new = sum_wide[32] ? S32_MIN : S32_MAX;
        end
        else
        begin
            sum_new = sum_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (in_accept)
        begin
            sum_reg  <= sum_new;
            prev_reg <= e_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e_reg <= e_new;
            d_reg <= e_new - prev_reg;
        end
    end

    // Shared multiplier, product registered.
    logic signed [32:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [67:0] prod_reg;
    logic [63:0]        mag_reg;
    logic [33:0]        gm_reg;
    logic               neg_reg;

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_KP_E:
            begin
                mul_a = $signed({1'b0, cfg.kp});
                mul_b = $signed({{27{e_reg[7]}}, e_reg});
            end
            MUL_KD_D:
            begin
                mul_a = $signed({1'b0, cfg.kd});
                mul_b = $signed({{27{d_reg[7]}}, d_reg});
            end
            MUL_KI_SUM:
            begin
                mul_a = $signed({1'b0, cfg.ki});
                mul_b = $signed({{3{sum_reg[31]}}, sum_reg});
            end
            MUL_LO_GM:
            begin
                mul_a = $signed({1'b0, mag_reg[31:0]});
                mul_b = $signed({1'b0, gm_reg});
            end
            MUL_HI_GM:
            begin
                mul_a = $signed({1'b0, mag_reg[63:32]});
                mul_b = $signed({1'b0, gm_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // PID accumulator with saturation on the last addition.
    logic signed [63:0] u_reg;
    logic signed [63:0] prod64;
    logic signed [63:0] u_add;
    logic               u_ovf;

    assign prod64 = prod_reg[63:0];
    assign u_add  = u_reg + prod64;
    assign u_ovf  = (u_reg[63] == prod64[63]) && (u_add[63] != u_reg[63]);

    always_ff @(posedge clk)
    begin
        case (ctrl.u_op)
            U_LOAD:   u_reg <= prod64;
            U_ADD:    u_reg <= u_add;
            U_ADDSAT: u_reg <= u_ovf ? (u_reg[63] ? S64_MIN : S64_MAX) : u_add;
            default:  u_reg <= u_reg;
        endcase
    end

    // Magnitude, sign and the speed gain scaled by 3 or 4 quarters.
    logic        slow;
    logic [33:0] g_ext;

    assign slow  = e_reg > $signed({2'b00, cfg.slow_threshold});
    assign g_ext = {2'b00, cfg.speed};

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_mag)
        begin
            neg_reg <= u_reg[63];
            mag_reg <= u_reg[63] ? (64'd0 - u_reg) : u_reg;
            gm_reg  <= slow ? ((g_ext << 1) + g_ext) : (g_ext << 2);
        end
    end

    // Steering angle.
    logic [63:0]        mag_sh;
    logic [Q_W-1:0]     steer_q;
    logic               steer_nz;
    logic signed [11:0] steer_tr;
    logic signed [11:0] sp_s;
    logic signed [11:0] steer_c;
    logic [ANG_W-1:0]   steer_new;
    logic [ANG_W-1:0]   steer_reg;

    assign mag_sh   = mag_reg >> GAIN_FRAC_BITS;
    assign steer_q  = (mag_sh > 64'(Q_CAP)) ? Q_CAP : mag_sh[Q_W-1:0];
    assign steer_nz = |(mag_reg & U_FRAC_MASK);
    assign steer_tr = trunc_sum(cfg.set_point, neg_reg, steer_q, steer_nz);
    assign sp_s     = $signed({3'b000, cfg.set_point});

    always_comb
    begin
        steer_c = steer_tr;
        if (steer_tr < sp_s - STEER_MARGIN)
        begin
            steer_c = sp_s - STEER_MARGIN;
        end
        else if (steer_tr > sp_s + STEER_MARGIN)
        begin
            steer_c = sp_s + STEER_MARGIN;
        end
        if (steer_c[11])
        begin
            steer_new = '0;
        end
        else if (steer_c > $signed({3'b000, STEER_MAX}))
        begin
            steer_new = STEER_MAX;
        end
        else
        begin
            steer_new = steer_c[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_steer)
        begin
            steer_reg <= steer_new;
        end
    end

    // Motor differential: two partial products summed into one wide register.
    logic [MOT_W-1:0]        mot_reg;
    logic [MOT_W-1:0]        mot_sh;
    logic [Q_W-1:0]          mot_q;
    logic                    mot_nz;
    logic signed [SPD_W-1:0] left_reg, right_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.m_op)
            M_LOAD:   mot_reg <= MOT_W'(prod_reg[65:0]);
            M_ADD_HI: mot_reg <= mot_reg + {prod_reg[64:0], 32'd0};
            default:  mot_reg <= mot_reg;
        endcase
    end

    assign mot_sh = mot_reg >> MSH;
    assign mot_q  = (mot_sh > MOT_W'(Q_CAP)) ? Q_CAP : mot_sh[Q_W-1:0];
    assign mot_nz = |(mot_reg & M_FRAC_MASK);

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_motor)
        begin
            left_reg  <= clamp_speed(trunc_sum({1'b0, cfg.base_speed}, neg_reg, mot_q, mot_nz));
            right_reg <= clamp_speed(trunc_sum({1'b0, cfg.base_speed}, !neg_reg, mot_q,
                                               mot_nz));
        end
    end

    // Output register.
    logic                    out_valid_reg;
    logic                    out_free;
    logic                    out_load;
    logic signed [SPD_W-1:0] left_out_reg, right_out_reg;
    logic [ANG_W-1:0]        steer_out_reg;
    logic                    last_out_reg;
    logic signed [SPD_W-1:0] left_sel, right_sel;
    logic [ANG_W-1:0]        steer_sel;
    logic                    last_sel;

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (ctrl.emit != EMIT_NONE) && out_free;

    always_comb
    begin
        case (ctrl.emit)
            EMIT_REVERSE:
            begin
                left_sel  = REV_SPEED;
                right_sel = REV_SPEED;
                steer_sel = (steer_reg <= LOW_LIMIT) ? HIGH_LIMIT : LOW_LIMIT;
                last_sel  = 1'b0;
            end
            EMIT_STOP:
            begin
                left_sel  = '0;
                right_sel = '0;
                steer_sel = steer_reg;
                last_sel  = 1'b0;
            end
            default:
            begin
                left_sel  = left_reg;
                right_sel = right_reg;
                steer_sel = steer_reg;
                last_sel  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= left_sel;
            right_out_reg <= right_sel;
            steer_out_reg <= steer_sel;
            last_out_reg  <= last_sel;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_speed  = left_out_reg;
    assign right_speed = right_out_reg;
    assign steer_angle = steer_out_reg;
    assign last        = last_out_reg;

    assign status_dp.in_valid = 1'b0;
    assign status_dp.out_free = out_free;
    assign status_dp.at_limit = (steer_reg <= LOW_LIMIT) || (steer_reg >= HIGH_LIMIT);

endmodule

// ----- hw/rtl/line_follow_pid_steering.sv -----
// Top level of the line follow PID steering controller.
// Depends on lfps_pkg, the three channel interfaces, lfps_cfg_regs, lfps_seq,
// lfps_datapath and line_follow_pid_steering_defines.svh.
//
//   Channel   Direction  Payload                                       Request
//   line_in   in         line_column                                   one camera frame
//   cmd_out   out        left_speed, right_speed, steer_angle, last    one command
//   cfg       in         index, data                                   one register write
//
// A request on line_in is taken in the wait step. Its final command is loaded into the
// output register in the final step, which the motor step jumps to directly when the
// steering stays inside the limits; otherwise a reverse and a stop command go first.
// The sequencer then returns to the wait step for the next request. The microprogram
// runs its steps in order: five products run one after another through the single
// 33 by 35 bit multiplier, each followed by its accumulate step.
// A command waits in the output register while cmd_out.ready is low, and the sequencer
// holds on its emit step until the register frees up; line_in is ready only in the
// wait step. Reset restores the register defaults and clears the error sum and the
// previous error. Configuration writes are always taken.
`include "line_follow_pid_steering_defines.svh"

module line_follow_pid_steering import lfps_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lfps_line_if.sink   line_in,
    lfps_cmd_if.source  cmd_out,
    lfps_cfg_if.sink    cfg
);

    cfg_t    cfg_vals;
    ctrl_t   ctrl;
    status_t status_dp;
    status_t status;
    logic    in_accept;

    // Registers are written whenever a write shows up; the port never stalls.
    assign cfg.ready = 1'b1;

    lfps_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_vals)
    );

    // The sequencer steps through the program; only its wait step takes a request.
    assign line_in.ready = ctrl.take_in;
    assign in_accept     = line_in.valid && ctrl.take_in;

    assign status.in_valid = line_in.valid;
    assign status.out_free = status_dp.out_free;
    assign status.at_limit = status_dp.at_limit;

    lfps_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // The datapath follows the control word of the current step.
    lfps_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg         (cfg_vals),
        .in_accept   (in_accept),
        .line_column (line_in.line_column),
        .out_ready   (cmd_out.ready),
        .status_dp   (status_dp),
        .out_valid   (cmd_out.valid),
        .left_speed  (cmd_out.left_speed),
        .right_speed (cmd_out.right_speed),
        .steer_angle (cmd_out.steer_angle),
        .last        (cmd_out.last)
    );

    // Only one request is in work at a time.
    `LFPS_ASSERT_NEXT(a_one_request, line_in.valid && line_in.ready, !line_in.ready, "input taken twice in a row")

    // A reverse command drives both motors backward and points the servo at the far limit.
    `LFPS_ASSERT_SAME(a_reverse_cmd, cmd_out.valid && !cmd_out.last && (cmd_out.left_speed != 9'sd0), (cmd_out.right_speed == REV_SPEED) && ((cmd_out.steer_angle == LOW_LIMIT) || (cmd_out.steer_angle == HIGH_LIMIT)), "bad reverse command")

    // A stop command halts both motors and only appears at a steering limit.
    `LFPS_ASSERT_SAME(a_stop_cmd, cmd_out.valid && !cmd_out.last && (cmd_out.left_speed == 9'sd0), (cmd_out.right_speed == 9'sd0) && ((cmd_out.steer_angle <= LOW_LIMIT) || (cmd_out.steer_angle >= HIGH_LIMIT)), "bad stop command")

endmodule
